[hdl/rkf_pkg.sv]
// rkf_pkg: shared constants, types, saturation helpers and the step program
// of the range Kalman filter. No dependencies.
package rkf_pkg;

  localparam int COV_FRAC_BITS = 16;
  localparam int DT_FRAC_BITS  = 16;
  localparam int POS_FRAC      = 16;
  localparam int GAIN_FRAC     = 32;

  localparam int COV_W = 48;
  localparam int ST_W  = 32;
  localparam int DT_W  = 24;
  localparam int Y_W   = 34;
  localparam int EST_W = 15;
  localparam int NUM_W = COV_W + GAIN_FRAC;
  localparam int PC_W  = 4;

  localparam logic signed [63:0] COV_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] COV_LO = 64'shFFFF_8000_0000_0000;
  localparam logic signed [63:0] ST_HI  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] ST_LO  = 64'shFFFF_FFFF_8000_0000;

  localparam logic [63:0] RNG_CAP  = 64'd1 << 40;
  localparam logic [63:0] COV_CAP  = 64'd1 << COV_W;
  localparam logic [63:0] CORR_CAP = 64'd1 << 33;
  localparam logic [63:0] GAIN_CAP = 64'd1 << 62;

  localparam logic CMD_FORGET = 1'b1;

  localparam logic [1:0] REG_RANGE_PV = 2'd0;
  localparam logic [1:0] REG_RATE_PV  = 2'd1;
  localparam logic [1:0] REG_INIT_RV  = 2'd2;

  localparam logic [PC_W-1:0] PC_DIV0 = 4'd7;
  localparam logic [PC_W-1:0] PC_LAST = 4'd14;

  typedef enum logic [1:0] {K_OP, K_MUL, K_DIV} kind_t;
  typedef enum logic [2:0] {A_RATE, A_P0, A_P1, A_P2, A_P3, A_Y, A_K0, A_K1} a_sel_t;
  typedef enum logic [2:0] {B_DT, B_K0, B_K1, B_P0, B_P1} b_sel_t;
  typedef enum logic [1:0] {SH_DT, SH_CORR, SH_GAIN} sh_t;
  typedef enum logic [1:0] {CAP_RNG, CAP_COV, CAP_CORR} cap_t;
  typedef enum logic [4:0] {
    WB_NONE, WB_RNG_ADD, WB_P0_ADD, WB_P1_ADD, WB_P0_ADDQ, WB_P2_ADD, WB_P3_Q,
    WB_PREP, WB_K0, WB_K1, WB_RNG_CORR, WB_RATE_CORR,
    WB_P0_SUB, WB_P1_SUB, WB_P2_SUB, WB_P3_SUB, WB_INIT
  } wb_t;

  typedef struct packed {
    kind_t  kind;
    a_sel_t a;
    b_sel_t b;
    sh_t    sh;
    cap_t   cap;
    wb_t    wb;
  } rkf_step_t;

  typedef struct packed {
    logic   load_in;
    logic   start_mul;
    logic   start_div;
    logic   wb_en;
    logic   out_load;
    a_sel_t a;
    b_sel_t b;
    sh_t    sh;
    cap_t   cap;
    wb_t    wb;
  } rkf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic s_pos;
  } rkf_sts_t;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [63:0] v);
    if (v > ST_HI) return ST_HI[ST_W-1:0];
    if (v < ST_LO) return ST_LO[ST_W-1:0];
    return v[ST_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [63:0] v);
    if (v > COV_HI) return COV_HI[COV_W-1:0];
    if (v < COV_LO) return COV_LO[COV_W-1:0];
    return v[COV_W-1:0];
  endfunction

  // integer variance to covariance format, saturated at the top
  function automatic logic signed [63:0] to_cov(input logic [31:0] v);
    logic [63:0] t;
    t = {32'd0, v} << COV_FRAC_BITS;
    if (t > $unsigned(COV_HI)) return COV_HI;
    return $signed(t);
  endfunction

  // predict then update, one arithmetic step per entry
  function automatic rkf_step_t rkf_micro(input logic [PC_W-1:0] pc);
    rkf_step_t st;
    unique case (pc)
      4'd0:  st = '{K_MUL, A_RATE, B_DT, SH_DT,   CAP_RNG,  WB_RNG_ADD};
      4'd1:  st = '{K_MUL, A_P2,   B_DT, SH_DT,   CAP_COV,  WB_P0_ADD};
      4'd2:  st = '{K_MUL, A_P3,   B_DT, SH_DT,   CAP_COV,  WB_P1_ADD};
      4'd3:  st = '{K_MUL, A_P1,   B_DT, SH_DT,   CAP_COV,  WB_P0_ADDQ};
      4'd4:  st = '{K_MUL, A_P3,   B_DT, SH_DT,   CAP_COV,  WB_P2_ADD};
      4'd5:  st = '{K_OP,  A_P3,   B_DT, SH_DT,   CAP_COV,  WB_P3_Q};
      4'd6:  st = '{K_OP,  A_P0,   B_DT, SH_DT,   CAP_COV,  WB_PREP};
      4'd7:  st = '{K_DIV, A_P0,   B_DT, SH_DT,   CAP_COV,  WB_K0};
      4'd8:  st = '{K_DIV, A_P2,   B_DT, SH_DT,   CAP_COV,  WB_K1};
      4'd9:  st = '{K_MUL, A_Y,    B_K0, SH_CORR, CAP_CORR, WB_RNG_CORR};
      4'd10: st = '{K_MUL, A_Y,    B_K1, SH_CORR, CAP_CORR, WB_RATE_CORR};
      4'd11: st = '{K_MUL, A_K1,   B_P0, SH_GAIN, CAP_COV,  WB_P2_SUB};
      4'd12: st = '{K_MUL, A_K1,   B_P1, SH_GAIN, CAP_COV,  WB_P3_SUB};
      4'd13: st = '{K_MUL, A_K0,   B_P0, SH_GAIN, CAP_COV,  WB_P0_SUB};
      4'd14: st = '{K_MUL, A_K0,   B_P1, SH_GAIN, CAP_COV,  WB_P1_SUB};
      default: st = '{K_OP, A_P0,  B_DT, SH_DT,   CAP_COV,  WB_NONE};
    endcase
    return st;
  endfunction

endpackage

[hdl/range_kalman_filter.sv]
// range_kalman_filter: top level, sequencer plus datapath.
// The first measure after reset or forget only loads the state and passes
// through the init and finish states to its estimate; a full predict/update
// runs eleven multiplies and two restoring divides, plus two add steps.
// A forget item yields no result. One item at a time.
// Reset (rst, synchronous) clears the sequencer and restores config defaults.
module range_kalman_filter import rkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // config write port: range_process_var, rate_process_var, initial_rate_var
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // measure channel
  input  logic               meas_valid,
  output logic               meas_stall,
  input  logic               command,
  input  logic [23:0]        elapsed_time,
  input  logic signed [15:0] measured_range,
  input  logic [15:0]        range_accuracy,
  // estimate channel, held in an output register so the next item can enter
  output logic               est_valid,
  input  logic               est_stall,
  output logic [14:0]        range_estimate
);

  rkf_cmd_t cmd;
  rkf_sts_t sts;

  // sequencer: idle, init, step program, wait on mul/div, result handoff
  rkf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .command    (command),
    .est_stall  (est_stall),
    .sts        (sts),
    .meas_stall (meas_stall),
    .est_valid  (est_valid),
    .cmd        (cmd)
  );

  // datapath: filter state, covariance, gains and arithmetic units
  rkf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .elapsed_time   (elapsed_time),
    .measured_range (measured_range),
    .range_accuracy (range_accuracy),
    .cmd            (cmd),
    .sts            (sts),
    .range_estimate (range_estimate)
  );

endmodule

[hdl/rkf_mul.sv]
// rkf_mul: sequential signed multiplier, 64x16 bits per cycle, with a
// truncating shift and magnitude cap. Depends on rkf_pkg.
module rkf_mul import rkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  sh_t                sh,
  input  cap_t               cap,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  ma, mb;
  logic         neg;
  sh_t          sh_r;
  cap_t         cap_r;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy, fin;
  logic [79:0]  part;
  logic [127:0] shifted;
  logic [63:0]  capv, mag;

  assign part = ma * mb[{cnt, 4'b0} +: 16];

  always_comb begin
    unique case (sh_r)
      SH_DT:   shifted = acc >> DT_FRAC_BITS;
      SH_CORR: shifted = acc >> (GAIN_FRAC + POS_FRAC);
      SH_GAIN: shifted = acc >> GAIN_FRAC;
      default: shifted = acc;
    endcase
    unique case (cap_r)
      CAP_RNG:  capv = RNG_CAP;
      CAP_COV:  capv = COV_CAP;
      CAP_CORR: capv = CORR_CAP;
      default:  capv = COV_CAP;
    endcase
    mag = (shifted > {64'd0, capv}) ? capv : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma    <= a[63] ? 64'(-a) : 64'(a);
      mb    <= b[63] ? 64'(-b) : 64'(b);
      neg   <= a[63] ^ b[63];
      sh_r  <= sh;
      cap_r <= cap;
      acc   <= '0;
    end else if (busy) begin
      acc <= acc + ({48'd0, part} << {cnt, 4'b0});
    end
    if (fin) res <= neg ? -$signed(mag) : $signed(mag);
  end

endmodule

[hdl/rkf_div.sv]
// rkf_div: restoring divider for the Kalman gains, one quotient bit per
// cycle, numerator scaled by 2^GAIN_FRAC. Depends on rkf_pkg.
module rkf_div import rkf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [COV_W-1:0] num,
  input  logic [COV_W-1:0]        den,
  output logic                    done,
  output logic signed [63:0]      res
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] nq;
  logic [COV_W-1:0] rem, dr;
  logic             neg, busy, fin, ge;
  logic [CNT_W-1:0] cnt;
  logic [COV_W:0]   remsh, diff;
  logic [63:0]      mag;

  assign remsh = {rem, nq[NUM_W-1]};
  assign ge    = remsh >= {1'b0, dr};
  assign diff  = remsh - {1'b0, dr};
  assign mag   = (nq > NUM_W'(GAIN_CAP)) ? GAIN_CAP : nq[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == CNT_W'(NUM_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // magnitude is unsigned: the most negative value gives 2^47, not a sign
      nq  <= {{GAIN_FRAC{1'b0}},
              (num[COV_W-1] ? COV_W'(-num) : COV_W'(num))} << GAIN_FRAC;
      rem <= '0;
      dr  <= den;
      neg <= num[COV_W-1];
    end else if (busy) begin
      rem <= ge ? diff[COV_W-1:0] : remsh[COV_W-1:0];
      nq  <= {nq[NUM_W-2:0], ge};
    end
    if (fin) res <= neg ? -$signed(mag) : $signed(mag);
  end

endmodule

[hdl/rkf_ctrl.sv]
// rkf_ctrl: sequencer of the range Kalman filter; walks the step program
// and drives the datapath by command struct. Depends on rkf_pkg.
module rkf_ctrl import rkf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     meas_valid,
  input  logic     command,
  input  logic     est_stall,
  input  rkf_sts_t sts,
  output logic     meas_stall,
  output logic     est_valid,
  output rkf_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_WMUL = 3'd3;
  localparam logic [2:0] ST_WDIV = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic            started, started_next, est_valid_next;
  rkf_step_t       step;

  assign step       = rkf_micro(pc);
  assign meas_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.a          = step.a;
    cmd.b          = step.b;
    cmd.sh         = step.sh;
    cmd.cap        = step.cap;
    cmd.wb         = step.wb;
    state_next     = state;
    pc_next        = pc;
    started_next   = started;
    est_valid_next = est_valid && est_stall;
    unique case (state)
      ST_IDLE: begin
        if (meas_valid) begin
          cmd.load_in = 1'b1;
          if (command == CMD_FORGET) begin
            started_next = 1'b0;
          end else if (started) begin
            pc_next    = '0;
            state_next = ST_RUN;
          end else begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.wb       = WB_INIT;
        cmd.wb_en    = 1'b1;
        started_next = 1'b1;
        state_next   = ST_FIN;
      end
      ST_RUN: begin
        if (pc == PC_DIV0 && !sts.s_pos) begin
          state_next = ST_FIN;
        end else begin
          unique case (step.kind)
            K_MUL: begin
              cmd.start_mul = 1'b1;
              state_next    = ST_WMUL;
            end
            K_DIV: begin
              cmd.start_div = 1'b1;
              state_next    = ST_WDIV;
            end
            default: begin
              cmd.wb_en = 1'b1;
              pc_next   = pc + 1'b1;
            end
          endcase
        end
      end
      ST_WMUL: begin
        if (sts.mul_done) begin
          cmd.wb_en = 1'b1;
          if (pc == PC_LAST) begin
            state_next = ST_FIN;
          end else begin
            pc_next    = pc + 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_WDIV: begin
        if (sts.div_done) begin
          cmd.wb_en  = 1'b1;
          pc_next    = pc + 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_FIN: begin
        if (!est_valid || !est_stall) begin
          cmd.out_load   = 1'b1;
          est_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      started   <= 1'b0;
      est_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      started   <= started_next;
      est_valid <= est_valid_next;
    end
  end

endmodule

[hdl/rkf_dp.sv]
// rkf_dp: datapath of the range Kalman filter: state, covariance, gains,
// config registers, shared adder, multiplier and divider. Depends on rkf_pkg.
module rkf_dp import rkf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [DT_W-1:0]    elapsed_time,
  input  logic signed [15:0] measured_range,
  input  logic [15:0]        range_accuracy,
  input  rkf_cmd_t           cmd,
  output rkf_sts_t           sts,
  output logic [EST_W-1:0]   range_estimate
);

  logic [15:0]              range_pv, rate_pv, init_rv;
  logic [DT_W-1:0]          dt;
  logic signed [15:0]       meas;
  logic [31:0]              acc_sq;
  logic signed [ST_W-1:0]   rng, rate;
  logic signed [COV_W-1:0]  p0, p1, p2, p3, s;
  logic signed [Y_W-1:0]    y;
  logic signed [63:0]       k0, k1;
  logic signed [63:0]       mul_a, mul_b, mul_res, div_res;
  logic                     mul_done, div_done;
  logic signed [COV_W-1:0]  div_num;
  logic signed [63:0]       base, addv, extra, sum;
  logic signed [ST_W-1:0]   meas_pos;

  assign meas_pos = $signed({meas, 16'd0});

  always_comb begin
    unique case (cmd.a)
      A_RATE:  mul_a = 64'(rate);
      A_P0:    mul_a = 64'(p0);
      A_P1:    mul_a = 64'(p1);
      A_P2:    mul_a = 64'(p2);
      A_P3:    mul_a = 64'(p3);
      A_Y:     mul_a = 64'(y);
      A_K0:    mul_a = k0;
      A_K1:    mul_a = k1;
      default: mul_a = '0;
    endcase
    unique case (cmd.b)
      B_DT:    mul_b = $signed(64'(dt));
      B_K0:    mul_b = k0;
      B_K1:    mul_b = k1;
      B_P0:    mul_b = 64'(p0);
      B_P1:    mul_b = 64'(p1);
      default: mul_b = '0;
    endcase
  end

  assign div_num = (cmd.a == A_P2) ? p2 : p0;

  rkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (cmd.sh),
    .cap   (cmd.cap),
    .done  (mul_done),
    .res   (mul_res)
  );

  rkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .num   (div_num),
    .den   ($unsigned(s)),
    .done  (div_done),
    .res   (div_res)
  );

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.s_pos    = !s[COV_W-1] && (s != '0);

  // one shared three-input adder for all state and covariance updates but init
  always_comb begin
    base  = '0;
    addv  = '0;
    extra = '0;
    unique case (cmd.wb)
      WB_RNG_ADD:   begin base = 64'(rng); addv = mul_res; end
      WB_P0_ADD:    begin base = 64'(p0);  addv = mul_res; end
      WB_P1_ADD:    begin base = 64'(p1);  addv = mul_res; end
      WB_P0_ADDQ:   begin
        base  = 64'(p0);
        addv  = mul_res;
        extra = to_cov(32'(range_pv));
      end
      WB_P2_ADD:    begin base = 64'(p2);  addv = mul_res; end
      WB_P3_Q:      begin base = 64'(p3);  extra = to_cov(32'(rate_pv)); end
      WB_PREP:      begin base = 64'(p0);  extra = to_cov(acc_sq); end
      WB_RNG_CORR:  begin base = 64'(rng);  addv = mul_res <<< POS_FRAC; end
      WB_RATE_CORR: begin base = 64'(rate); addv = mul_res <<< POS_FRAC; end
      WB_P0_SUB:    begin base = 64'(p0);  addv = -mul_res; end
      WB_P1_SUB:    begin base = 64'(p1);  addv = -mul_res; end
      WB_P2_SUB:    begin base = 64'(p2);  addv = -mul_res; end
      WB_P3_SUB:    begin base = 64'(p3);  addv = -mul_res; end
      default: ;
    endcase
    sum = base + addv + extra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_pv <= 16'd0;
      rate_pv  <= 16'd25;
      init_rv  <= 16'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_PV: range_pv <= cfg_data;
        REG_RATE_PV:  rate_pv  <= cfg_data;
        REG_INIT_RV:  init_rv  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dt     <= elapsed_time;
      meas   <= measured_range;
      acc_sq <= range_accuracy * range_accuracy;
    end
    if (cmd.out_load) begin
      range_estimate <= rng[ST_W-1] ? '0 : rng[POS_FRAC +: EST_W];
    end
    if (cmd.wb_en) begin
      unique case (cmd.wb)
        WB_RNG_ADD, WB_RNG_CORR: rng <= sat_st(sum);
        WB_RATE_CORR:            rate <= sat_st(sum);
        WB_P0_ADD, WB_P0_ADDQ, WB_P0_SUB: p0 <= sat_cov(sum);
        WB_P1_ADD, WB_P1_SUB:    p1 <= sat_cov(sum);
        WB_P2_ADD, WB_P2_SUB:    p2 <= sat_cov(sum);
        WB_P3_Q, WB_P3_SUB:      p3 <= sat_cov(sum);
        WB_PREP: begin
          s <= sat_cov(sum);
          y <= Y_W'(meas_pos) - Y_W'(rng);
        end
        WB_K0: k0 <= div_res;
        WB_K1: k1 <= div_res;
        WB_INIT: begin
          rng  <= meas_pos;
          rate <= '0;
          p1   <= '0;
          p2   <= '0;
          p0   <= sat_cov(to_cov(acc_sq));
          p3   <= sat_cov(to_cov(32'(init_rv)));
        end
        default: ;
      endcase
    end
  end

endmodule

[test/testbench.sv]
// testbench: self-checking bench for range_kalman_filter (predict/update Kalman filter).
// Depends on rkf_pkg and range_kalman_filter; a scoreboard class predicts every estimate.
module testbench;
  import rkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  // Scoreboard: bit-accurate filter state and queue of pending estimates
  class est_scoreboard;
    bit started;
    longint range_st, rate_st;
    longint cov[4];
    longint rng_pv, rate_pv, init_rv;
    bit [14:0] est_q[$];
    int errors;

    function new();
      started = 0; range_st = 0; rate_st = 0;
      foreach (cov[i]) cov[i] = 0;
      rng_pv = 0; rate_pv = 25; init_rv = 25; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == REG_RANGE_PV) rng_pv = v;
      else if (idx == REG_RATE_PV) rate_pv = v;
      else if (idx == REG_INIT_RV) init_rv = v;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction
    function longint scov(longint v);
      return clampl(v, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    endfunction
    function longint s32(longint v);
      return clampl(v, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    endfunction
    function longint tocov(longint v);
      return scov(v <<< COV_FRAC_BITS);
    endfunction

    // a*b >> s, truncated toward zero, magnitude capped
    function longint mshift(longint a, longint b, int s, logic [63:0] cap);
      logic [127:0] p;
      logic [127:0] m;
      logic [63:0] mag;
      logic [63:0] ma, mb;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = ma * mb;
      m = p >> s;
      mag = (m > {64'd0, cap}) ? cap : m[63:0];
      return ((a < 0) != (b < 0)) ? -$signed(mag) : $signed(mag);
    endfunction

    // p * 2^32 / s, truncated toward zero, capped at 2^62
    function longint kgain(longint p, longint s);
      logic [127:0] n, q;
      logic [63:0] mp, mag;
      mp = p < 0 ? -p : p;
      n = {64'd0, mp} << GAIN_FRAC;
      q = n / s;
      mag = (q > {64'd0, GAIN_CAP}) ? GAIN_CAP : q[63:0];
      return p < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    // note an accepted item; returns 1 when it makes an estimate
    function bit note_item(bit cmd, logic [23:0] dt, logic signed [15:0] mr,
                           logic [15:0] acc);
      longint d, meas, y, s, k0, k1, c0, c1, p0, p1, whole;
      d = dt; meas = mr;
      if (cmd == CMD_FORGET) begin
        started = 0;
        return 0;
      end
      if (!started) begin
        started = 1;
        range_st = meas * 65536; rate_st = 0;
        cov[1] = 0; cov[2] = 0;
        cov[0] = tocov(longint'(acc) * acc);
        cov[3] = tocov(init_rv);
      end else begin
        // predict
        range_st = s32(range_st + mshift(rate_st, d, DT_FRAC_BITS, RNG_CAP));
        cov[0] = scov(cov[0] + mshift(cov[2], d, DT_FRAC_BITS, COV_CAP));
        cov[1] = scov(cov[1] + mshift(cov[3], d, DT_FRAC_BITS, COV_CAP));
        cov[0] = scov(cov[0] + mshift(cov[1], d, DT_FRAC_BITS, COV_CAP) + tocov(rng_pv));
        cov[2] = scov(cov[2] + mshift(cov[3], d, DT_FRAC_BITS, COV_CAP));
        cov[3] = scov(cov[3] + tocov(rate_pv));
        // update, skipped when innovation variance is not positive
        y = meas * 65536 - range_st;
        s = scov(cov[0] + tocov(longint'(acc) * acc));
        if (s > 0) begin
          k0 = kgain(cov[0], s);
          k1 = kgain(cov[2], s);
          c0 = mshift(y, k0, GAIN_FRAC + POS_FRAC, CORR_CAP);
          c1 = mshift(y, k1, GAIN_FRAC + POS_FRAC, CORR_CAP);
          range_st = s32(range_st + c0 * 65536);
          rate_st = s32(rate_st + c1 * 65536);
          p0 = cov[0]; p1 = cov[1];
          cov[0] = scov(p0 - mshift(k0, p0, GAIN_FRAC, COV_CAP));
          cov[1] = scov(p1 - mshift(k0, p1, GAIN_FRAC, COV_CAP));
          cov[2] = scov(cov[2] - mshift(k1, p0, GAIN_FRAC, COV_CAP));
          cov[3] = scov(cov[3] - mshift(k1, p1, GAIN_FRAC, COV_CAP));
        end
      end
      whole = range_st < 0 ? 0 : (range_st >>> POS_FRAC);
      est_q.push_back(15'(clampl(whole, 0, 32767)));
      return 1;
    endfunction

    function void check_estimate(logic [14:0] got);
      bit [14:0] want;
      if (est_q.size() == 0) begin
        report("estimate with nothing pending", got, 0);
        return;
      end
      want = est_q.pop_front();
      if (got !== want) report("range_estimate mismatch", got, want);
    endfunction

    function void report(string what, longint got, longint want);
      $display("ERROR %0t: %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic meas_valid = 0;
  logic meas_stall;
  logic command = 0;
  logic [23:0] elapsed_time = 0;
  logic signed [15:0] measured_range = 0;
  logic [15:0] range_accuracy = 0;
  logic est_valid;
  logic est_stall = 0;
  logic [14:0] range_estimate;

  est_scoreboard sb = new();
  int idle_pct = 24;   // idle probability on both sides, zeroed for a calm stretch
  int quiet_cycles = 0;
  bit done = 0;

  range_kalman_filter dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // output side: random stall, check every accepted estimate
  always @(posedge clk) begin
    if (!rst && est_valid && !est_stall) sb.check_estimate(range_estimate);
    est_stall <= ($urandom_range(99) < idle_pct);
  end

  // watchdog: cycles in which no item moves on either channel
  always @(posedge clk) begin
    if ((meas_valid && !meas_stall) || (est_valid && !est_stall) || rst || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // config write while the filter is idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
  endtask

  // drive one item, hold it until accepted, optionally idle afterwards
  task automatic send_item(bit cmd, logic [23:0] dt, logic signed [15:0] mr,
                           logic [15:0] acc);
    meas_valid <= 1; command <= cmd; elapsed_time <= dt;
    measured_range <= mr; range_accuracy <= acc;
    do @(posedge clk); while (meas_stall);
    void'(sb.note_item(cmd, dt, mr, acc));
    if ($urandom_range(99) < idle_pct) begin
      meas_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // let the filter drain: all estimates out, then a full update's latency
  task automatic drain();
    meas_valid <= 0;
    while (sb.est_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random measure item: mostly a tracked target with modest dt and noise
  task automatic random_item(ref int trk);
    int pick;
    logic [23:0] dt;
    logic [15:0] acc;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_item(CMD_FORGET, 24'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    if (pick < 14) begin
      // noise: any field value
      send_item(1'b0, 24'($urandom), 16'($urandom), 16'($urandom));
      return;
    end
    dt = 24'($urandom_range(1000, 40000));
    acc = 16'($urandom_range(0, 400));
    trk = trk + $signed($urandom_range(0, 400)) - 200;
    if (trk > 32767) trk = 32767;
    if (trk < -32768) trk = -32768;
    send_item(1'b0, dt, 16'(trk + $signed($urandom_range(0, 2 * acc)) - acc), acc);
  endtask

  initial begin
    int trk;
    logic [15:0] cfg_sets[4][3];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, forget, zero accuracy, negative range
    send_item(0, 0, 16'sh7FFF, 16'hFFFF);
    send_item(0, 24'hFFFFFF, 16'sh8000, 0);
    send_item(0, 24'hFFFFFF, 16'sh7FFF, 16'hFFFF);
    send_item(CMD_FORGET, 0, 0, 0);
    send_item(0, 24'h010000, -16'sd100, 5);
    send_item(0, 24'h010000, 16'sd200, 0);
    send_item(0, 24'h008000, 16'sd300, 10);
    send_item(CMD_FORGET, 24'hFFFFFF, 16'shFFFF, 16'hFFFF);
    send_item(0, 0, 0, 0);
    send_item(0, 0, 0, 0);                // zero innovation variance: update skipped
    send_item(0, 24'h000001, 16'sh8000, 16'h8000);
    send_item(0, 24'h800000, 16'sh7FFF, 1);
    send_item(0, 24'h7FFFFF, 16'sh4000, 16'h7FFF);
    drain();

    // config phases, extremes included; each phase shares the item budget
    cfg_sets[0] = '{16'd0, 16'd0, 16'd0};
    cfg_sets[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    cfg_sets[2] = '{16'd100, 16'd25, 16'd400};
    cfg_sets[3] = '{16'($urandom), 16'($urandom), 16'($urandom)};
    trk = 1000;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_reg(REG_RANGE_PV, cfg_sets[ph][0]);
        write_reg(REG_RATE_PV, cfg_sets[ph][1]);
        write_reg(REG_INIT_RV, cfg_sets[ph][2]);
      end else begin
        write_reg(REG_RANGE_PV, 16'd0);
        write_reg(REG_RATE_PV, 16'd25);
        write_reg(REG_INIT_RV, 16'd25);
      end
      for (int n = 0; n < 325; n++) begin
        idle_pct = (ph == 2 && n < 120) ? 0 : 24;   // calm stretch, no idling
        random_item(trk);
      end
      idle_pct = 24;
      drain();
    end

    done = 1;
    if (sb.errors == 0 && sb.est_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
